### rtl/rlb_pkg.sv
// Shared types, constants and register codes of the RGBW line blur block.
package rlb_pkg;

    localparam int CHAN_W        = 8;
    localparam int NUM_CHAN      = 4;
    localparam int PIX_W         = CHAN_W * NUM_CHAN;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 8;
    localparam int FIFO_DEPTH_DEF = 4;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLUR_AMOUNT = 1'b0,
        CFG_SMEAR_MODE  = 1'b1
    } cfg_index_t;

    // One result item as it sits in the output queue
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } result_t;

    // Products of the per-pixel math
    typedef struct packed {
        logic [PIX_W-1:0] mid;   // previous pixel completed with this one's seep part
        logic [PIX_W-1:0] cur;   // kept part of this pixel plus its left spill
        logic [PIX_W-1:0] part;  // seep part of this pixel
    } math_t;

endpackage

### rtl/rlb_if.sv
// Handshake interfaces of the RGBW line blur block: pixels, results, configuration.
interface rlb_pix_if
    import rlb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             line_end;

    modport source (output valid, output pixel_in, output line_end, input ready);
    modport sink   (input valid, input pixel_in, input line_end, output ready);
endinterface

interface rlb_res_if
    import rlb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             line_last;

    modport source (output valid, output pixel_out, output line_last, input ready);
    modport sink   (input valid, input pixel_out, input line_last, output ready);
endinterface

interface rlb_cfg_if
    import rlb_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

### rtl/rlb_pixel_math.sv
// Per-pixel scaling by keep and seep factors and saturating spill adds.
module rlb_pixel_math
    import rlb_pkg::*;
(
    input  logic [PIX_W-1:0]  pixel,
    input  logic [CHAN_W-1:0] keep,
    input  logic [CHAN_W-1:0] seep,
    input  logic [PIX_W-1:0]  held,
    input  logic [PIX_W-1:0]  spill,
    output math_t             res
);

    // channel * (factor + 1) >> 8; factor 255 passes, factor 0 gives black
    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] ch,
                                                     input logic [CHAN_W-1:0] factor);
        logic [2*CHAN_W:0] prod;
        prod = {{(CHAN_W+1){1'b0}}, ch} * ({{(CHAN_W+1){1'b0}}, factor} + (2*CHAN_W+1)'(1));
        return prod[2*CHAN_W-1:CHAN_W];
    endfunction

    function automatic logic [CHAN_W-1:0] sat_chan(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        logic [CHAN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CHAN_W] ? {CHAN_W{1'b1}} : s[CHAN_W-1:0];
    endfunction

    logic [PIX_W-1:0] kept;
    logic [PIX_W-1:0] part;
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] mid;

    // four independent channel lanes
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            kept[c*CHAN_W +: CHAN_W] = scale_chan(pixel[c*CHAN_W +: CHAN_W], keep);
            part[c*CHAN_W +: CHAN_W] = scale_chan(pixel[c*CHAN_W +: CHAN_W], seep);
        end
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            cur[c*CHAN_W +: CHAN_W] = sat_chan(kept[c*CHAN_W +: CHAN_W],
                                               spill[c*CHAN_W +: CHAN_W]);
            mid[c*CHAN_W +: CHAN_W] = sat_chan(held[c*CHAN_W +: CHAN_W],
                                               part[c*CHAN_W +: CHAN_W]);
        end
    end

    assign res.mid  = mid;
    assign res.cur  = cur;
    assign res.part = part;

endmodule

### rtl/rlb_out_fifo.sv
// Result queue: takes up to two items a cycle, gives one a cycle while the reader is ready.
module rlb_out_fifo
    import rlb_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_n,
    input  result_t    push0,
    input  result_t    push1,
    output logic       space2,
    rlb_res_if.source  res
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg;
    logic [PTR_W-1:0]   wr_next;
    logic [PTR_W-1:0]   rd_reg;
    logic [PTR_W-1:0]   rd_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    assign pop    = res.valid & res.ready;
    assign space2 = (count_reg <= CNT_W'(DEPTH - 2));

    // pointer and fill count
    always_comb
    begin
        unique case (push_n)
            2'd0:    wr_next = wr_reg;
            2'd1:    wr_next = ptr_inc(wr_reg);
            default: wr_next = ptr_inc(ptr_inc(wr_reg));
        endcase
        rd_next    = pop ? ptr_inc(rd_reg) : rd_reg;
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem_reg[wr_reg] <= push0;
        if (push_n == 2'd2)
            mem_reg[ptr_inc(wr_reg)] <= push1;
    end

    assign res.valid     = (count_reg != '0);
    assign res.pixel_out = mem_reg[rd_reg].pixel;
    assign res.line_last = mem_reg[rd_reg].last;

endmodule

### rtl/rgbw_line_blur_unit.sv
// Top level of the RGBW line blur: input register, pixel math, line state, result queue.
//
// Three-tap blur over one line of packed WRGB pixels (W 31..24, R 23..16, G 15..8,
// B 7..0). Unless stalled, the block takes one pixel per clock into an input register;
// from there the pixel is scaled, combined with its neighbours' spill and written into
// a result queue (FIFO_DEPTH items, default 4). The result for a pixel appears when
// the following pixel of the line arrives; at line_end the last pixel is flushed as
// well, with line_last set, so a line of N pixels gives N results. Results leave the
// queue one per clock while the reader is ready. The input side stalls only while the
// queue holds fewer than two free entries. Configuration writes are always taken and
// should be made between lines while no results are pending.
module rgbw_line_blur_unit
    import rlb_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    rlb_cfg_if.sink   cfg,
    rlb_pix_if.sink   pixels,
    rlb_res_if.source results
);

    logic [CHAN_W-1:0] blur_amount_reg;
    logic              smear_mode_reg;

    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic              s1_last_reg;

    logic [PIX_W-1:0]  held_new_reg;
    logic [PIX_W-1:0]  held_new_next;
    logic [PIX_W-1:0]  spill_carry_reg;
    logic [PIX_W-1:0]  spill_carry_next;
    logic              at_line_start_reg;
    logic              at_line_start_next;

    logic [CHAN_W-1:0] keep;
    logic [CHAN_W-1:0] seep;
    math_t             math;
    logic              space2;
    logic              fire;
    logic [1:0]        push_n;
    result_t           push0;
    result_t           push1;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blur_amount_reg <= '0;
            smear_mode_reg  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.reg_index))
                CFG_BLUR_AMOUNT: blur_amount_reg <= cfg.wdata;
                CFG_SMEAR_MODE:  smear_mode_reg  <= cfg.wdata[0];
            endcase
        end
    end

    // input register
    assign fire         = s1_valid_reg & space2;
    assign pixels.ready = ~s1_valid_reg | fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pixels.ready)
            s1_valid_reg <= pixels.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pixels.valid && pixels.ready)
        begin
            s1_pix_reg  <= pixels.pixel_in;
            s1_last_reg <= pixels.line_end;
        end
    end

    // scale factors
    assign keep = smear_mode_reg ? {CHAN_W{1'b1}} : ~blur_amount_reg;
    assign seep = {1'b0, blur_amount_reg[CHAN_W-1:1]};

    rlb_pixel_math u_math (
        .pixel (s1_pix_reg),
        .keep  (keep),
        .seep  (seep),
        .held  (held_new_reg),
        .spill (spill_carry_reg),
        .res   (math)
    );

    // results of this pixel: completed left neighbour, then flush at line end
    always_comb
    begin
        push_n = 2'd0;
        if (fire)
            push_n = 2'({1'b0, ~at_line_start_reg} + {1'b0, s1_last_reg});
        push0.pixel = at_line_start_reg ? math.cur : math.mid;
        push0.last  = at_line_start_reg;
        push1.pixel = math.cur;
        push1.last  = 1'b1;
    end

    // line state
    always_comb
    begin
        held_new_next      = held_new_reg;
        spill_carry_next   = spill_carry_reg;
        at_line_start_next = at_line_start_reg;
        if (fire)
        begin
            if (s1_last_reg)
            begin
                held_new_next      = '0;
                spill_carry_next   = '0;
                at_line_start_next = 1'b1;
            end
            else
            begin
                held_new_next      = math.cur;
                spill_carry_next   = math.part;
                at_line_start_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_new_reg      <= '0;
            spill_carry_reg   <= '0;
            at_line_start_reg <= 1'b1;
        end
        else
        begin
            held_new_reg      <= held_new_next;
            spill_carry_reg   <= spill_carry_next;
            at_line_start_reg <= at_line_start_next;
        end
    end

    rlb_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_n (push_n),
        .push0  (push0),
        .push1  (push1),
        .space2 (space2),
        .res    (results)
    );

    // a line start carries no spill and no held pixel
    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        at_line_start_reg |-> (spill_carry_reg == '0) && (held_new_reg == '0))
        else $error("line start with stale neighbour state");

    // a line-end pixel leaves the block at a line start
    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_last_reg |=> at_line_start_reg)
        else $error("line end did not restart the line");

    // a pixel in mid-line pushes at least one result
    a_mid_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !at_line_start_reg |-> push_n != 2'd0)
        else $error("mid-line pixel produced no result");

    // the input register is only refilled when its pixel has gone on
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !space2 |=> s1_valid_reg && $stable(s1_pix_reg))
        else $error("stalled pixel was lost");

endmodule
